FILE: rtl/core/direct_dft_forward_inverse_unit_macros.svh
// Assertion macros for the checker file of the direct DFT unit.
`ifndef DIRECT_DFT_FORWARD_INVERSE_UNIT_MACROS_SVH
`define DIRECT_DFT_FORWARD_INVERSE_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define DDFT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ddft: same-cycle implication violated");

// next-cycle implication, off during reset
`define DDFT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ddft: next-cycle implication violated");

// next-cycle implication, checked through reset as well
`define DDFT_ASSERT_NEXT_NORST(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("ddft: reset behavior violated");

`endif

FILE: rtl/core/ddft_pkg.sv
// Types, constants and the twiddle table of the direct DFT unit.
package ddft_pkg;

   localparam int MAX_POINTS_DEF   = 64;
   localparam int TWIDDLE_BITS_DEF = 16;

   localparam int SAMPLE_W   = 16;
   localparam int BIN_W      = 23;
   localparam int LG_W       = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 3;
   localparam int PHASE_W    = 6;
   localparam int TABLE_LG   = 6;
   localparam int COS_W      = 31;
   localparam int TW_MAX_W   = 25;

   localparam logic [CSR_IDX_W-1:0] CSR_INVERSE_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOG2_POINTS  = 2'd1;

   localparam logic [LG_W-1:0] LOG2_POINTS_RST = 3'd6;

   typedef logic [COS_W-1:0] cos_row_type;

   // cos(2*pi*m/64) for m = 0..16, unsigned Q1.30
   localparam cos_row_type COS_Q30 [17] = '{
      31'd1073741824, 31'd1068571463, 31'd1053110176, 31'd1027506862,
      31'd992008094,  31'd946955747,  31'd892783698,  31'd830013654,
      31'd759250125,  31'd681174602,  31'd596538995,  31'd506158392,
      31'd410903207,  31'd311690800,  31'd209476638,  31'd105245103,
      31'd0
   };

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_ISSUE,
      ST_FLUSH,
      ST_ROUND,
      ST_SAT,
      ST_EMIT
   } state_type;

   // cosine of 2*pi*m/64 as Q1.(twb-1), rounded half away from zero, +1.0 saturated
   function automatic logic signed [TW_MAX_W-1:0] twiddle_cos(
      input logic [PHASE_W-1:0] m,
      input int                 twb
   );
      logic [1:0]                 q;
      logic [3:0]                 r;
      logic [COS_W-1:0]           base;
      logic [COS_W:0]             rnd;
      logic [COS_W:0]             lim;
      logic [COS_W:0]             mag;
      logic signed [TW_MAX_W-1:0] t;
      int                         sh;
      q = m[5:4];
      r = m[3:0];
      if (q == 2'd0 || q == 2'd2) begin
         base = COS_Q30[{1'b0, r}];
      end else begin
         base = COS_Q30[5'd16 - {1'b0, r}];
      end
      sh  = 31 - twb;
      rnd = ({1'b0, base} + (32'd1 << (sh - 1))) >> sh;
      lim = (32'd1 << (twb - 1)) - 32'd1;
      mag = (rnd > lim) ? lim : rnd;
      t   = $signed(TW_MAX_W'(mag));
      twiddle_cos = (q == 2'd1 || q == 2'd2) ? -t : t;
   endfunction

endpackage

FILE: rtl/core/direct_dft_forward_inverse_unit.sv
// Direct DFT, forward or inverse, over N = 2^log2_points complex Q1.15 samples.
// Samples enter one beat per cycle into a sample memory; the beat that completes
// a block of N starts the transform and the block stalls its input until the
// last bin beat is taken. Each bin is built on one complex multiply-accumulate
// unit (four multipliers) that walks the N stored samples, one per cycle, with
// twiddles from a quarter-wave cosine table, then rounds, shifts (by log2 N as
// well in forward mode) and saturates to 23 bits. The bins are built one after
// another on that one shared MAC. log2_points above the supported range is
// clamped to the largest power of two not above MAX_POINTS or 64, whichever is
// smaller. Write the control registers only while the block is idle.
module direct_dft_forward_inverse_unit import ddft_pkg::*; #(
   parameter int MAX_POINTS   = MAX_POINTS_DEF,
   parameter int TWIDDLE_BITS = TWIDDLE_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [SAMPLE_W-1:0]  req_sample_re,
   input  logic signed [SAMPLE_W-1:0]  req_sample_im,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [BIN_W-1:0]     rsp_bin_re,
   output logic signed [BIN_W-1:0]     rsp_bin_im,
   output logic                        rsp_last_bin,
   input  logic                        csr_wr_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wr_data
);

   localparam int MAX_LG  = $clog2(MAX_POINTS + 1) - 1;
   localparam int DEPTH   = 1 << MAX_LG;
   localparam int IDX_W   = MAX_LG;
   localparam int CNT_W   = MAX_LG + 1;
   localparam int ENTRY_W = 2 * SAMPLE_W;
   localparam int PROD_W  = SAMPLE_W + TWIDDLE_BITS;
   localparam int ACC_W   = PROD_W + MAX_LG + 2;
   localparam int SH_W    = $clog2(TWIDDLE_BITS + MAX_LG);

   localparam logic [PHASE_W:0]         FULL_TURN   = (PHASE_W + 1)'(1 << PHASE_W);
   localparam logic [PHASE_W-1:0]       THREE_QTR   = PHASE_W'(3 << (PHASE_W - 2));
   localparam logic signed [ACC_W-1:0]  ONE_S       = ACC_W'(1);
   localparam logic signed [ACC_W-1:0]  BIN_HI      = ACC_W'((1 << (BIN_W - 1)) - 1);
   localparam logic signed [ACC_W-1:0]  BIN_LO      = -ACC_W'(1 << (BIN_W - 1));

   state_type state_ff, state_in;

   logic                             inverse_mode_ff, inverse_mode_in;
   logic [LG_W-1:0]                  log2_points_ff, log2_points_in;
   logic [IDX_W-1:0]                 load_cnt_ff, load_cnt_in;
   logic [IDX_W-1:0]                 n_ff, n_in;
   logic [IDX_W-1:0]                 k_ff, k_in;
   logic [PHASE_W-1:0]               phase_ff, phase_in;
   logic [PHASE_W-1:0]               step_ff, step_in;
   logic                             s1_vld_ff, s1_vld_in;
   logic                             s2_vld_ff, s2_vld_in;

   logic [ENTRY_W-1:0]               sample_mem [DEPTH];
   logic [ENTRY_W-1:0]               rd_data_ff;
   logic signed [TWIDDLE_BITS-1:0]   cos_ff, cos_in;
   logic signed [TWIDDLE_BITS-1:0]   sin_ff, sin_in;
   logic signed [TWIDDLE_BITS-1:0]   sin_raw;
   logic signed [SAMPLE_W-1:0]       xr, xi;
   logic signed [PROD_W-1:0]         p_rc_ff, p_rc_in;
   logic signed [PROD_W-1:0]         p_is_ff, p_is_in;
   logic signed [PROD_W-1:0]         p_ic_ff, p_ic_in;
   logic signed [PROD_W-1:0]         p_rs_ff, p_rs_in;
   logic signed [ACC_W-1:0]          acc_re_ff, acc_re_in;
   logic signed [ACC_W-1:0]          acc_im_ff, acc_im_in;
   logic signed [ACC_W-1:0]          rnd_re_ff, rnd_re_in;
   logic signed [ACC_W-1:0]          rnd_im_ff, rnd_im_in;
   logic signed [ACC_W-1:0]          half_s, bias_re, bias_im;
   logic signed [BIN_W-1:0]          bin_re_ff, bin_re_in;
   logic signed [BIN_W-1:0]          bin_im_ff, bin_im_in;
   logic                             last_ff, last_in;

   logic [LG_W-1:0]                  lg_cap, lg;
   logic [CNT_W-1:0]                 npts;
   logic [IDX_W-1:0]                 last_idx;
   logic [PHASE_W-1:0]               stride;
   logic [SH_W-1:0]                  shamt;
   logic                             load_done;

   logic                             load_wr, issue, run_start, next_bin;
   logic                             do_round, do_sat;

   // transform length and scaling
   always_comb begin
      lg_cap    = (log2_points_ff > LG_W'(TABLE_LG)) ? LG_W'(TABLE_LG) : log2_points_ff;
      lg        = (lg_cap > LG_W'(MAX_LG)) ? LG_W'(MAX_LG) : lg_cap;
      npts      = CNT_W'(1) << lg;
      last_idx  = IDX_W'(npts - CNT_W'(1));
      stride    = PHASE_W'(FULL_TURN >> lg);
      shamt     = SH_W'(TWIDDLE_BITS - 1) + (inverse_mode_ff ? SH_W'(0) : SH_W'(lg));
      load_done = ({1'b0, load_cnt_ff} + CNT_W'(1)) >= npts;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid && load_done) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (n_ff == last_idx) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!s1_vld_ff && !s2_vld_ff) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            state_in = ST_SAT;
         end
         ST_SAT: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               state_in = (k_ff == last_idx) ? ST_LOAD : ST_ISSUE;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      load_wr   = 1'b0;
      issue     = 1'b0;
      run_start = 1'b0;
      next_bin  = 1'b0;
      do_round  = 1'b0;
      do_sat    = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            load_wr   = req_valid;
            run_start = req_valid && load_done;
         end
         ST_ISSUE: begin
            issue = 1'b1;
         end
         ST_FLUSH: begin
         end
         ST_ROUND: begin
            do_round = 1'b1;
         end
         ST_SAT: begin
            do_sat = 1'b1;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            next_bin  = !rsp_stall && (k_ff != last_idx);
         end
         default: begin
         end
      endcase
   end

   // control next values
   always_comb begin
      inverse_mode_in = inverse_mode_ff;
      log2_points_in  = log2_points_ff;
      if (csr_wr_en && csr_index == CSR_INVERSE_MODE) begin
         inverse_mode_in = csr_wr_data[0];
      end
      if (csr_wr_en && csr_index == CSR_LOG2_POINTS) begin
         log2_points_in = csr_wr_data[LG_W-1:0];
      end

      load_cnt_in = load_cnt_ff;
      if (load_wr) begin
         load_cnt_in = load_done ? '0 : load_cnt_ff + IDX_W'(1);
      end

      k_in    = k_ff;
      step_in = step_ff;
      if (run_start) begin
         k_in    = '0;
         step_in = '0;
      end else if (next_bin) begin
         k_in    = k_ff + IDX_W'(1);
         step_in = step_ff + stride;
      end

      n_in     = n_ff;
      phase_in = phase_ff;
      if (run_start || next_bin) begin
         n_in     = '0;
         phase_in = '0;
      end else if (issue) begin
         n_in     = (n_ff == last_idx) ? '0 : n_ff + IDX_W'(1);
         phase_in = phase_ff + step_ff;
      end

      s1_vld_in = issue;
      s2_vld_in = s1_vld_ff;
   end

   // twiddles, products, accumulate, round and saturate
   always_comb begin
      cos_in  = TWIDDLE_BITS'(twiddle_cos(phase_ff, TWIDDLE_BITS));
      sin_raw = TWIDDLE_BITS'(twiddle_cos(phase_ff + THREE_QTR, TWIDDLE_BITS));
      sin_in  = inverse_mode_ff ? sin_raw : -sin_raw;

      xr      = $signed(rd_data_ff[ENTRY_W-1:SAMPLE_W]);
      xi      = $signed(rd_data_ff[SAMPLE_W-1:0]);
      p_rc_in = xr * cos_ff;
      p_is_in = xi * sin_ff;
      p_ic_in = xi * cos_ff;
      p_rs_in = xr * sin_ff;

      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      if (run_start || next_bin) begin
         acc_re_in = '0;
         acc_im_in = '0;
      end else if (s2_vld_ff) begin
         acc_re_in = acc_re_ff + ACC_W'(p_rc_ff) - ACC_W'(p_is_ff);
         acc_im_in = acc_im_ff + ACC_W'(p_ic_ff) + ACC_W'(p_rs_ff);
      end

      half_s    = $signed(ACC_W'(1) << (shamt - SH_W'(1)));
      bias_re   = acc_re_ff[ACC_W-1] ? half_s - ONE_S : half_s;
      bias_im   = acc_im_ff[ACC_W-1] ? half_s - ONE_S : half_s;
      rnd_re_in = (acc_re_ff + bias_re) >>> shamt;
      rnd_im_in = (acc_im_ff + bias_im) >>> shamt;

      bin_re_in = BIN_W'((rnd_re_ff > BIN_HI) ? BIN_HI :
                         ((rnd_re_ff < BIN_LO) ? BIN_LO : rnd_re_ff));
      bin_im_in = BIN_W'((rnd_im_ff > BIN_HI) ? BIN_HI :
                         ((rnd_im_ff < BIN_LO) ? BIN_LO : rnd_im_ff));
      last_in   = (k_ff == last_idx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_LOAD;
         inverse_mode_ff <= 1'b0;
         log2_points_ff  <= LOG2_POINTS_RST;
         load_cnt_ff     <= '0;
         n_ff            <= '0;
         k_ff            <= '0;
         phase_ff        <= '0;
         step_ff         <= '0;
         s1_vld_ff       <= 1'b0;
         s2_vld_ff       <= 1'b0;
      end else begin
         state_ff        <= state_in;
         inverse_mode_ff <= inverse_mode_in;
         log2_points_ff  <= log2_points_in;
         load_cnt_ff     <= load_cnt_in;
         n_ff            <= n_in;
         k_ff            <= k_in;
         phase_ff        <= phase_in;
         step_ff         <= step_in;
         s1_vld_ff       <= s1_vld_in;
         s2_vld_ff       <= s2_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_wr) begin
         sample_mem[load_cnt_ff] <= {req_sample_re, req_sample_im};
      end
      if (issue) begin
         rd_data_ff <= sample_mem[n_ff];
      end
   end

   always_ff @(posedge clock) begin
      cos_ff    <= cos_in;
      sin_ff    <= sin_in;
      p_rc_ff   <= p_rc_in;
      p_is_ff   <= p_is_in;
      p_ic_ff   <= p_ic_in;
      p_rs_ff   <= p_rs_in;
      acc_re_ff <= acc_re_in;
      acc_im_ff <= acc_im_in;
      if (do_round) begin
         rnd_re_ff <= rnd_re_in;
         rnd_im_ff <= rnd_im_in;
      end
      if (do_sat) begin
         bin_re_ff <= bin_re_in;
         bin_im_ff <= bin_im_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_bin_re   = bin_re_ff;
   assign rsp_bin_im   = bin_im_ff;
   assign rsp_last_bin = last_ff;

endmodule

FILE: rtl/core/ddft_checker.sv
// Port-level checker for the direct DFT unit and its bind.
`include "direct_dft_forward_inverse_unit_macros.svh"

module ddft_checker import ddft_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic signed [BIN_W-1:0]    rsp_bin_re,
   input logic signed [BIN_W-1:0]    rsp_bin_im,
   input logic                       rsp_last_bin
);

   `DDFT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_bin_re) && $stable(rsp_bin_im) && $stable(rsp_last_bin))

   `DDFT_ASSERT_IMPLY(a_busy_while_emit, clock, reset, rsp_valid, req_stall)

   `DDFT_ASSERT_NEXT(a_idle_after_last, clock, reset, rsp_valid && !rsp_stall && rsp_last_bin, !rsp_valid && !req_stall)

   `DDFT_ASSERT_NEXT(a_no_bin_after_load, clock, reset, req_valid && !req_stall, !rsp_valid)

   `DDFT_ASSERT_NEXT_NORST(a_reset_idle, clock, reset, !rsp_valid && !req_stall)

endmodule

bind direct_dft_forward_inverse_unit ddft_checker u_ddft_checker (.*);

FILE: test/ddft_bin_checker.sv
// Bin checker for the direct DFT unit: tracks samples and settings, predicts and compares bins.
module ddft_bin_checker import ddft_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample_re,
   input  logic signed [SAMPLE_W-1:0] req_sample_im,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic signed [BIN_W-1:0]    rsp_bin_re,
   input  logic signed [BIN_W-1:0]    rsp_bin_im,
   input  logic                       rsp_last_bin,
   input  logic                       csr_wr_en,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wr_data,
   output int                         mismatch_count,
   output int                         bins_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     PHASES     = 1 << TABLE_LG;
   localparam int     MAX_LG     = $clog2(MAX_POINTS_DEF);
   localparam int     TW_SHIFT   = 31 - TWIDDLE_BITS_DEF;
   localparam longint TW_LIM     = (longint'(1) << (TWIDDLE_BITS_DEF - 1)) - 1;
   localparam longint BIN_MAX    = (longint'(1) << (BIN_W - 1)) - 1;
   localparam longint BIN_MIN    = -(longint'(1) << (BIN_W - 1));

   localparam longint QUARTER_COS [17] = '{
      1073741824, 1068571463, 1053110176, 1027506862, 992008094,
      946955747,  892783698,  830013654,  759250125,  681174602,
      596538995,  506158392,  410903207,  311690800,  209476638,
      105245103,  0
   };

   typedef struct {
      logic signed [BIN_W-1:0] re;
      logic signed [BIN_W-1:0] im;
      logic                    last;
   } bin_beat_type;

   bin_beat_type               expected_bins [$];
   bin_beat_type               head_bin;
   logic signed [SAMPLE_W-1:0] held_re [PHASES];
   logic signed [SAMPLE_W-1:0] held_im [PHASES];
   int unsigned                load_count;
   int unsigned                active_lg;
   logic                       inverse_sel;
   logic [LG_W-1:0]            lg_setting;

   function automatic longint cos_at(int unsigned m);
      int unsigned quad;
      int unsigned rem;
      longint      base;
      longint      mag;
      quad = (m % PHASES) / 16;
      rem  = m % 16;
      base = (quad == 0 || quad == 2) ? QUARTER_COS[rem] : QUARTER_COS[16 - rem];
      mag  = (base + (longint'(1) << (TW_SHIFT - 1))) >>> TW_SHIFT;
      if (mag > TW_LIM) begin
         mag = TW_LIM;
      end
      return (quad == 1 || quad == 2) ? -mag : mag;
   endfunction

   function automatic longint round_shift(longint v, int unsigned s);
      longint half;
      half = longint'(1) << (s - 1);
      if (v < 0) begin
         return -((-v + half) >>> s);
      end
      return (v + half) >>> s;
   endfunction

   function automatic logic signed [BIN_W-1:0] clamp_bin(longint v);
      longint c;
      c = v;
      if (c > BIN_MAX) begin
         c = BIN_MAX;
      end
      if (c < BIN_MIN) begin
         c = BIN_MIN;
      end
      return c[BIN_W-1:0];
   endfunction

   // push the N bins of the transform over the first N held samples
   task automatic transform_block(int unsigned lg);
      int unsigned  pts;
      int unsigned  stride;
      int unsigned  shift;
      int unsigned  idx;
      longint       acc_re;
      longint       acc_im;
      longint       c;
      longint       s;
      longint       xr;
      longint       xi;
      bin_beat_type b;
      pts    = 1 << lg;
      stride = PHASES >> lg;
      shift  = (TWIDDLE_BITS_DEF - 1) + (inverse_sel ? 0 : lg);
      for (int unsigned k = 0; k < pts; k++) begin
         acc_re = 0;
         acc_im = 0;
         for (int unsigned n = 0; n < pts; n++) begin
            idx = (k * n * stride) % PHASES;
            c   = cos_at(idx);
            s   = cos_at((idx + 48) % PHASES);
            xr  = held_re[n];
            xi  = held_im[n];
            if (inverse_sel) begin
               acc_re += xr * c - xi * s;
               acc_im += xi * c + xr * s;
            end else begin
               acc_re += xr * c + xi * s;
               acc_im += xi * c - xr * s;
            end
         end
         b.re   = clamp_bin(round_shift(acc_re, shift));
         b.im   = clamp_bin(round_shift(acc_im, shift));
         b.last = (k == pts - 1);
         expected_bins.push_back(b);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_bins.delete();
         load_count     = 0;
         inverse_sel    = 1'b0;
         lg_setting     = LOG2_POINTS_RST;
         mismatch_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_bins.size() == 0) begin
               $error("unexpected bin beat: re %0d im %0d last %0b",
                      rsp_bin_re, rsp_bin_im, rsp_last_bin);
               mismatch_count++;
            end else begin
               head_bin = expected_bins.pop_front();
               if (rsp_bin_re !== head_bin.re) begin
                  $error("bin_re mismatch: expected %0d, actual %0d", head_bin.re, rsp_bin_re);
                  mismatch_count++;
               end
               if (rsp_bin_im !== head_bin.im) begin
                  $error("bin_im mismatch: expected %0d, actual %0d", head_bin.im, rsp_bin_im);
                  mismatch_count++;
               end
               if (rsp_last_bin !== head_bin.last) begin
                  $error("last_bin mismatch: expected %0b, actual %0b",
                         head_bin.last, rsp_last_bin);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            active_lg = (lg_setting > MAX_LG) ? MAX_LG : lg_setting;
            held_re[load_count % PHASES] = req_sample_re;
            held_im[load_count % PHASES] = req_sample_im;
            load_count = (load_count + 1) % 128;
            if (load_count >= (1 << active_lg)) begin
               transform_block(active_lg);
               load_count = 0;
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_INVERSE_MODE: begin
                  inverse_sel = csr_wr_data[0];
               end
               CSR_LOG2_POINTS: begin
                  lg_setting = csr_wr_data[LG_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
      bins_pending <= expected_bins.size();
   end

endmodule

FILE: test/direct_dft_forward_inverse_unit_tb.sv
// Testbench top for the direct DFT unit: clock, reset, sample and setting stimulus, verdict.
module direct_dft_forward_inverse_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ddft_pkg::*;

   localparam int SETTLE_CYCLES  = 80;
   localparam int TAIL_CYCLES    = 200;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RESET_CYCLES   = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   localparam logic signed [SAMPLE_W-1:0] S_MAX  = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] S_MIN  = 16'sh8000;
   localparam logic signed [SAMPLE_W-1:0] S_ZERO = 16'sh0000;

   logic                       clock         = 1'b0;
   logic                       reset         = 1'b1;
   logic                       req_valid     = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample_re = '0;
   logic signed [SAMPLE_W-1:0] req_sample_im = '0;
   logic                       rsp_valid;
   logic                       rsp_stall     = 1'b0;
   logic signed [BIN_W-1:0]    rsp_bin_re;
   logic signed [BIN_W-1:0]    rsp_bin_im;
   logic                       rsp_last_bin;
   logic                       csr_wr_en     = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index     = '0;
   logic [CSR_DATA_W-1:0]      csr_wr_data   = '0;

   int mismatch_count;
   int bins_pending;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int samples_sent   = 0;
   int bins_taken     = 0;
   int phases_run     = 0;
   int quiet_cycles   = 0;

   int unsigned phase_lg [12] = '{7, 3, 0, 5, 1, 2, 4, 3, 6, 2, 1, 0};

   direct_dft_forward_inverse_unit u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sample_re (req_sample_re),
      .req_sample_im (req_sample_im),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_bin_re    (rsp_bin_re),
      .rsp_bin_im    (rsp_bin_im),
      .rsp_last_bin  (rsp_last_bin),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data)
   );

   ddft_bin_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_re  (req_sample_re),
      .req_sample_im  (req_sample_im),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_bin_re     (rsp_bin_re),
      .rsp_bin_im     (rsp_bin_im),
      .rsp_last_bin   (rsp_last_bin),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .bins_pending   (bins_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall && !reset) begin
         bins_taken <= bins_taken + 1;
      end
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat moved for %0d cycles", quiet_cycles);
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(9))
         0: return S_MAX;
         1: return S_MIN;
         2: return S_ZERO;
         3: return -16'sd1;
         4, 5: return SAMPLE_W'(int'($urandom_range(511)) - 256);
         default: return SAMPLE_W'($urandom_range(65535));
      endcase
   endfunction

   // hold payload until taken; drop valid only on an idle cycle
   task automatic send_beat(input logic signed [SAMPLE_W-1:0] re,
                            input logic signed [SAMPLE_W-1:0] im);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_re <= re;
      req_sample_im <= im;
      do @(posedge clock); while (req_stall);
      samples_sent++;
   endtask

   task automatic send_samples(input int count);
      for (int i = 0; i < count; i++) begin
         send_beat(pick_sample(), pick_sample());
      end
   endtask

   // drain all bins, then let the block settle before touching settings
   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (bins_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
         default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
   endtask

   initial begin
      int unsigned lg;
      int unsigned pts;
      int          blocks;
      int          extra;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // one-point forward, full-scale corners
      write_reg(CSR_INVERSE_MODE, 3'd0);
      write_reg(CSR_LOG2_POINTS, 3'd0);
      send_beat(S_MAX, S_MIN);
      send_beat(S_MIN, S_MAX);
      quiesce();
      // two-point inverse, upper data bits ignored
      write_reg(CSR_INVERSE_MODE, 3'd7);
      write_reg(CSR_LOG2_POINTS, 3'd1);
      send_beat(S_MAX, S_MAX);
      send_beat(S_MIN, S_MIN);
      quiesce();
      // four-point forward impulse, then inverse all-negative
      write_reg(CSR_INVERSE_MODE, 3'd6);
      write_reg(CSR_LOG2_POINTS, 3'd2);
      send_beat(S_MAX, S_ZERO);
      send_beat(S_ZERO, S_ZERO);
      send_beat(S_ZERO, S_ZERO);
      send_beat(S_ZERO, S_ZERO);
      quiesce();
      write_reg(CSR_INVERSE_MODE, 3'd1);
      for (int i = 0; i < 4; i++) begin
         send_beat(S_MIN, S_MIN);
      end
      quiesce();
      // spare indexes must not alias; shrink length with a partial load pending
      write_reg(CSR_INVERSE_MODE, 3'd0);
      write_reg(CSR_LOG2_POINTS, 3'd6);
      write_reg(CSR_SPARE_A, 3'd1);
      write_reg(CSR_SPARE_B, 3'd0);
      send_samples(6);
      quiesce();
      write_reg(CSR_LOG2_POINTS, 3'd2);
      send_samples(1);
      phases_run = 6;

      for (int p = 0; p < 12; p++) begin
         quiesce();
         set_idling(p % 4);
         lg     = phase_lg[p];
         pts    = 1 << ((lg > 6) ? 6 : lg);
         blocks = (pts >= 20) ? 1 : 20 / pts;
         extra  = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0;
         write_reg(CSR_INVERSE_MODE, CSR_DATA_W'(($urandom_range(3) << 1) | ((p >> 1) & 1)));
         write_reg(CSR_LOG2_POINTS, CSR_DATA_W'(lg));
         if ($urandom_range(2) == 0) begin
            write_reg(($urandom_range(1) == 0) ? CSR_SPARE_A : CSR_SPARE_B,
                      CSR_DATA_W'($urandom_range(7)));
         end
         send_samples(blocks * pts + extra);
         phases_run++;
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (bins_pending != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d samples and %0d bins over %0d setting phases", samples_sent,
               bins_taken, phases_run);
      $display("forward and inverse, N from 1 to 64 plus clamped length, gaps and stalls");
      if (mismatch_count == 0 && bins_pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
